// File: rtl/bat_pkg.sv
// Shared types and codes of the breakpoint address table.
`timescale 1ns / 1ps

package bat_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOTSET  = 2'd3
  } status_e;

  // Control states, one-hot
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  // Request transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  space_id;
    logic [63:0] bp_address;
    logic [15:0] skip_count;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] entry_count;
  } rsp_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [15:0] count;
  } token_t;

  // Slot write command broadcast to all cells
  typedef struct packed {
    logic set;
    logic clr;
  } wr_t;

endpackage

// File: rtl/bat_cell.sv
// One breakpoint slot: stored entry, compare, and one stage of the search chain.
`timescale 1ns / 1ps

module bat_cell #(
  parameter int SLOTS = 16,
  parameter int INDEX = 0,
  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         req_space_i,
  input  logic [63:0]        req_addr_i,
  input  logic [15:0]        req_skip_i,
  input  bat_pkg::wr_t       wr_i,
  input  logic [SlotW-1:0]   wr_slot_i,
  input  bat_pkg::token_t    tok_i,
  input  logic [SlotW-1:0]   tok_slot_i,
  output bat_pkg::token_t    tok_o,
  output logic [SlotW-1:0]   tok_slot_o
);
  import bat_pkg::*;

  logic              valid_q;
  logic [7:0]        space_q;
  logic [63:0]       addr_q;
  logic [15:0]       skip_q;
  logic              match;
  logic              sel;
  token_t            tok_d, tok_q;
  logic [SlotW-1:0]  tok_slot_d, tok_slot_q;

  // Compare the broadcast request against this slot
  assign match = valid_q && (space_q == req_space_i) && (addr_q == req_addr_i);
  assign sel   = (wr_slot_i == SlotW'(INDEX));

  // Keep an earlier hit, otherwise add this slot's hit to the token
  always_comb begin
    tok_d      = tok_i;
    tok_slot_d = tok_slot_i;
    if (tok_i.valid && !tok_i.hit && match) begin
      tok_d.hit   = 1'b1;
      tok_d.count = skip_q;
      tok_slot_d  = SlotW'(INDEX);
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
      tok_q.hit   <= 1'b0;
      tok_q.count <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_slot_q <= tok_slot_d;
  end

  // Slot valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel && wr_i.set) begin
      valid_q <= 1'b1;
    end else if (sel && wr_i.clr) begin
      valid_q <= 1'b0;
    end
  end

  // Slot payload, loaded on allocation
  always_ff @(posedge clk_i) begin
    if (sel && wr_i.set) begin
      space_q <= req_space_i;
      addr_q  <= req_addr_i;
      skip_q  <= req_skip_i;
    end
  end

  assign tok_o      = tok_q;
  assign tok_slot_o = tok_slot_q;

endmodule

// File: rtl/breakpoint_address_table_top.sv
// Top level of the breakpoint address table: control, freed-slot stack, chain of slot cells.
//
//  channel | direction | signals                          | payload
//  --------+-----------+----------------------------------+--------------
//  request | in        | in_valid_i / in_ready_o          | in_data_i
//  result  | out       | out_valid_o / out_ready_i        | out_data_o
//
// A result is presented once its request has been accepted and the search
// token has walked the chain one slot cell per cycle; the outcome is then
// captured in the result registers, and the update state changes the table and
// loads the output register. One request is in work at a time; the next is taken
// the cycle after the update, even while a result waits.
// The update stalls while the output register still holds an untaken result.
// Reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps

module breakpoint_address_table_top #(
  parameter int SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bat_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bat_pkg::rsp_t  out_data_o
);
  import bat_pkg::*;

  localparam int SlotW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DepthW = $clog2(SLOTS + 1);

  state_e             state_q, state_d;
  req_t               req_q;
  logic               launch_q;
  logic               accept;
  logic               fire;

  token_t             tok     [SLOTS+1];
  logic [SlotW-1:0]   tok_slot[SLOTS+1];
  logic [SLOTS-1:0]   tok_valid_vec;

  logic               res_hit_q;
  logic [SlotW-1:0]   res_slot_q;
  logic [15:0]        res_count_q;

  logic [SlotW-1:0]   stack_mem [SLOTS];
  logic [SlotW-1:0]   stack_rd_q;
  logic [DepthW-1:0]  depth_q, depth_d, depth_m1;
  logic [DepthW-1:0]  next_q, next_d;
  logic               push;

  wr_t                wr;
  logic [SlotW-1:0]   wr_slot;
  logic [SlotW-1:0]   slot_sel;
  logic [SlotW+3:0]   slot_ext;
  rsp_t               rsp;
  rsp_t               out_q;
  logic               out_valid_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);

  // Control sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_SWEEP;
      S_SWEEP:  if (tok[SLOTS].valid) state_d = S_UPDATE;
      S_UPDATE: if (fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept;
    end
  end

  // Hold the request for the whole transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
  end

  // Inject the search token at the head of the chain
  assign tok[0].valid = launch_q;
  assign tok[0].hit   = 1'b0;
  assign tok[0].count = '0;
  assign tok_slot[0]  = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    bat_cell #(
      .SLOTS (SLOTS),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .req_space_i (req_q.space_id),
      .req_addr_i  (req_q.bp_address),
      .req_skip_i  (req_q.skip_count),
      .wr_i        (wr),
      .wr_slot_i   (wr_slot),
      .tok_i       (tok[i]),
      .tok_slot_i  (tok_slot[i]),
      .tok_o       (tok[i+1]),
      .tok_slot_o  (tok_slot[i+1])
    );
    assign tok_valid_vec[i] = tok[i+1].valid;
  end

  // Capture the search outcome at the tail of the chain
  always_ff @(posedge clk_i) begin
    if (tok[SLOTS].valid) begin
      res_hit_q   <= tok[SLOTS].hit;
      res_slot_q  <= tok_slot[SLOTS];
      res_count_q <= tok[SLOTS].count;
    end
  end

  // Freed-slot stack: read top every cycle, push on delete
  assign depth_m1 = depth_q - DepthW'(1);

  always_ff @(posedge clk_i) begin
    stack_rd_q <= stack_mem[depth_m1[SlotW-1:0]];
    if (push) begin
      stack_mem[depth_q[SlotW-1:0]] <= res_slot_q;
    end
  end

  // Decide the result and the table update
  always_comb begin
    rsp.status      = ST_NOTSET;
    rsp.entry_count = '0;
    slot_sel        = '0;
    wr              = '0;
    wr_slot         = '0;
    push            = 1'b0;
    depth_d         = depth_q;
    next_d          = next_q;
    if (fire) begin
      unique case (req_q.op)
        OP_SET: begin
          if (res_hit_q) begin
            rsp.status = ST_ALREADY;
          end else if (depth_q != '0) begin
            rsp.status = ST_OK;
            slot_sel   = stack_rd_q;
            wr.set     = 1'b1;
            wr_slot    = stack_rd_q;
            depth_d    = depth_m1;
          end else if (next_q < DepthW'(SLOTS)) begin
            rsp.status = ST_OK;
            slot_sel   = next_q[SlotW-1:0];
            wr.set     = 1'b1;
            wr_slot    = next_q[SlotW-1:0];
            next_d     = next_q + DepthW'(1);
          end else begin
            rsp.status = ST_FULL;
          end
        end
        OP_DELETE: begin
          if (res_hit_q) begin
            rsp.status = ST_OK;
            slot_sel   = res_slot_q;
            wr.clr     = 1'b1;
            wr_slot    = res_slot_q;
            if (depth_q < DepthW'(SLOTS)) begin
              push    = 1'b1;
              depth_d = depth_q + DepthW'(1);
            end
          end
        end
        OP_FIND: begin
          if (res_hit_q) begin
            rsp.status      = ST_OK;
            slot_sel        = res_slot_q;
            rsp.entry_count = res_count_q;
          end
        end
        default: begin
          rsp.status = ST_NOTSET;
        end
      endcase
    end
    slot_ext = {4'b0000, slot_sel};
    rsp.slot = slot_ext[3:0];
  end

  // Allocation counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      next_q  <= '0;
    end else begin
      depth_q <= depth_d;
      next_q  <= next_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // At most one search token travels the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid_vec))
    else $error("more than one search token in the chain");

  // No token remains in the chain once the update starts
  a_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> (tok_valid_vec == '0))
    else $error("search token still in flight during update");

  // Freed slots never outnumber slots handed out
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= next_q)
    else $error("freed stack deeper than slots ever used");

  // An accepted request launches a search
  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (launch_q && state_q == S_SWEEP))
    else $error("accepted request did not launch a search");

  // A failed result carries no slot and no count
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rsp.status != ST_OK) |-> (rsp.slot == '0 && rsp.entry_count == '0))
    else $error("failed result carries slot or count");

endmodule

// File: tb/sv/tb.sv
// Testbench for the breakpoint address table: directed table walk, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb;
  import bat_pkg::*;

  localparam int SLOTS = 16;
  localparam int LATENCY = SLOTS + 3;
  localparam int N_ITEMS = 550;
  localparam int N_CALM = 60;
  localparam int N_KEYS = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] ADDR_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  breakpoint_address_table_top #(.SLOTS(SLOTS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the breakpoint table
  logic        bp_valid [SLOTS];
  logic [7:0]  bp_space [SLOTS];
  logic [63:0] bp_addr [SLOTS];
  logic [15:0] bp_skip [SLOTS];
  logic [3:0]  freed_lifo [SLOTS];
  int          freed_top;
  int          fresh_next;

  rsp_t rsp_due_q[$];
  int   mismatch_cnt;
  bit   calm;

  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t rsp;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]  sp;
    logic [63:0] a;
  } bp_key_t;

  // Apply one request to the shadow table and return the response it earns
  function automatic rsp_t table_response(req_t r);
    int   hit;
    int   s;
    rsp_t o;
    hit = -1;
    o = '0;
    o.status = ST_NOTSET;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && bp_valid[i] && bp_space[i] == r.space_id && bp_addr[i] == r.bp_address)
        hit = i;
    end
    case (r.op)
      OP_SET: begin
        s = -1;
        if (hit >= 0) begin
          o.status = ST_ALREADY;
        end else if (freed_top > 0) begin
          freed_top--;
          s = int'(freed_lifo[freed_top]);
        end else if (fresh_next < SLOTS) begin
          s = fresh_next;
          fresh_next++;
        end else begin
          o.status = ST_FULL;
        end
        if (s >= 0) begin
          bp_valid[s] = 1'b1;
          bp_space[s] = r.space_id;
          bp_addr[s] = r.bp_address;
          bp_skip[s] = r.skip_count;
          o.status = ST_OK;
          o.slot = s[3:0];
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          bp_valid[hit] = 1'b0;
          if (freed_top < SLOTS) begin
            freed_lifo[freed_top] = hit[3:0];
            freed_top++;
          end
          o.status = ST_OK;
          o.slot = hit[3:0];
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          o.status = ST_OK;
          o.slot = hit[3:0];
          o.entry_count = bp_skip[hit];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic dir_row_t row(logic [1:0] op, logic [7:0] sp, logic [63:0] a,
                                   logic [15:0] c, logic fx, logic [1:0] st,
                                   logic [3:0] sl, logic [15:0] ec);
    dir_row_t d;
    d.req = '{op: op, space_id: sp, bp_address: a, skip_count: c};
    d.fixed = fx;
    d.rsp = '{status: st, slot: sl, entry_count: ec};
    return d;
  endfunction

  // Present one transaction and hold it until accepted; valid is left high
  task automatic send_req(req_t r, logic fixed, rsp_t typed);
    rsp_t p;
    in_data_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    p = table_response(r);
    rsp_due_q.push_back(fixed ? typed : p);
  endtask

  // Drop valid for a random burst, some of the time
  task automatic sender_gap(int idx);
    if (!calm && ((idx / 40) % 3 != 0) && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("breakpoint_address_table_top: mismatch");
    $finish;
  end

  // Result side: ready with random stall bursts
  initial begin
    int cyc;
    out_ready_i = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!calm && ((cyc / 64) % 4 != 0) && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        cyc++;
      end
      out_ready_i <= 1'b1;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_due_q.size() == 0) begin
        $error("unexpected result: status %0d slot %0d entry_count %0d",
               out_data_o.status, out_data_o.slot, out_data_o.entry_count);
        mismatch_cnt++;
      end else begin
        e = rsp_due_q.pop_front();
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data_o.status);
          mismatch_cnt++;
        end
        if (out_data_o.slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, out_data_o.slot);
          mismatch_cnt++;
        end
        if (out_data_o.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0h, got %0h", e.entry_count, out_data_o.entry_count);
          mismatch_cnt++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t steer_tbl[$];
    bp_key_t  keys [N_KEYS];
    req_t     r;
    int       n_dir;
    int       pick;
    bit       set_heavy;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    mismatch_cnt = 0;
    calm = 1'b0;
    freed_top = 0;
    fresh_next = 0;
    for (int i = 0; i < SLOTS; i++) begin
      bp_valid[i] = 1'b0;
      bp_space[i] = '0;
      bp_addr[i] = '0;
      bp_skip[i] = '0;
      freed_lifo[i] = '0;
    end

    // Empty table, extremes, duplicates, freed-slot reuse order
    steer_tbl = '{
      row(OP_FIND, 8'd0, 64'd0, 16'd0, 1'b1, ST_NOTSET, 4'd0, 16'd0),
      row(OP_DELETE, 8'd0, 64'd0, 16'd0, 1'b1, ST_NOTSET, 4'd0, 16'd0),
      row(OP_UNUSED, 8'hFF, ADDR_ONES, 16'hFFFF, 1'b1, ST_NOTSET, 4'd0, 16'd0),
      row(OP_SET, 8'd0, 64'd0, 16'd0, 1'b1, ST_OK, 4'd0, 16'd0),
      row(OP_SET, 8'hFF, ADDR_ONES, 16'hFFFF, 1'b1, ST_OK, 4'd1, 16'd0),
      row(OP_SET, 8'd0, 64'd0, 16'h1234, 1'b1, ST_ALREADY, 4'd0, 16'd0),
      row(OP_FIND, 8'hFF, ADDR_ONES, 16'd0, 1'b1, ST_OK, 4'd1, 16'hFFFF),
      row(OP_FIND, 8'd0, 64'd0, 16'hFFFF, 1'b1, ST_OK, 4'd0, 16'd0),
      row(OP_FIND, 8'd1, 64'd0, 16'd0, 1'b1, ST_NOTSET, 4'd0, 16'd0),
      row(OP_FIND, 8'd0, 64'd1, 16'd0, 1'b1, ST_NOTSET, 4'd0, 16'd0),
      row(OP_UNUSED, 8'd0, 64'd0, 16'd0, 1'b1, ST_NOTSET, 4'd0, 16'd0),
      row(OP_DELETE, 8'd0, 64'd0, 16'd0, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_DELETE, 8'hFF, ADDR_ONES, 16'd0, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_SET, 8'hA5, 64'h5555_5555_5555_5555, 16'h00FF, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_SET, 8'h5A, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFF00, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_SET, 8'd3, 64'h8000_0000_0000_0001, 16'd7, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_FIND, 8'h5A, 64'hAAAA_AAAA_AAAA_AAAA, 16'd0, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_DELETE, 8'h5A, 64'hAAAA_AAAA_AAAA_AAAA, 16'd0, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_FIND, 8'h5A, 64'hAAAA_AAAA_AAAA_AAAA, 16'd0, 1'b1, ST_NOTSET, 4'd0, 16'd0),
      row(OP_SET, 8'hFF, ADDR_ONES, 16'd1, 1'b0, ST_OK, 4'd0, 16'd0),
      row(OP_FIND, 8'd3, 64'h8000_0000_0000_0001, 16'd0, 1'b0, ST_OK, 4'd0, 16'd0)
    };
    n_dir = steer_tbl.size();

    // Hold reset, then release it
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steer_tbl[i]) begin
      send_req(steer_tbl[i].req, steer_tbl[i].fixed, steer_tbl[i].rsp);
      sender_gap(i);
    end

    // Let the table drain once before random traffic
    in_valid_i <= 1'b0;
    wait (rsp_due_q.size() == 0);
    @(posedge clk_i);

    for (int i = 0; i < N_KEYS; i++) begin
      keys[i].sp = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
      keys[i].a = {$urandom, $urandom};
    end

    // Random traffic: alternate fill-heavy and drain-heavy phases over a small key pool
    for (int n = n_dir; n < N_ITEMS; n++) begin
      if (n >= N_ITEMS - N_CALM) calm = 1'b1;
      if (n == 300) begin
        in_valid_i <= 1'b0;
        wait (rsp_due_q.size() == 0);
        @(posedge clk_i);
      end
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, N_KEYS - 1);
        keys[pick].sp = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        keys[pick].a = {$urandom, $urandom};
      end
      set_heavy = ((n / 60) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (pick < 4) r.op = OP_UNUSED;
      else if (pick < (set_heavy ? 64 : 20)) r.op = OP_SET;
      else if (pick < (set_heavy ? 79 : 75)) r.op = OP_DELETE;
      else r.op = OP_FIND;
      if ($urandom_range(0, 19) != 0) begin
        pick = $urandom_range(0, N_KEYS - 1);
        r.space_id = keys[pick].sp;
        r.bp_address = keys[pick].a;
      end else begin
        r.space_id = 8'($urandom);
        r.bp_address = {$urandom, $urandom};
      end
      case ($urandom_range(0, 9))
        0: r.skip_count = 16'd0;
        1: r.skip_count = 16'hFFFF;
        default: r.skip_count = 16'($urandom);
      endcase
      send_req(r, 1'b0, '0);
      sender_gap(n);
    end

    // Drain
    in_valid_i <= 1'b0;
    wait (rsp_due_q.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatch_cnt == 0 && rsp_due_q.size() == 0) begin
      $display("breakpoint_address_table_top: match");
    end else begin
      $display("breakpoint_address_table_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bat_pkg.sv
rtl/bat_cell.sv
rtl/breakpoint_address_table_top.sv
tb/sv/tb.sv
